FILE: rtl/seam_cumulative_energy_assert.svh
// -----------------------------------------------------------------------------
// seam_cumulative_energy_assert.svh
// Assertion macros used by the seam energy RTL (sce_energy).
// -----------------------------------------------------------------------------
`ifndef SEAM_CUMULATIVE_ENERGY_ASSERT_SVH
`define SEAM_CUMULATIVE_ENERGY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sce_pkg.sv
// -----------------------------------------------------------------------------
// sce_pkg
// Types and fixed constants of the seam cumulative energy block.
// -----------------------------------------------------------------------------
package sce_pkg;

   localparam int GRAD_BITS         = 24;
   localparam int ENERGY_BITS       = 36;
   localparam int ROW_WIDTH_BITS    = 11;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int REQ_DATA_BITS     = 24;
   localparam int RSP_DATA_BITS     = 40;

   localparam logic [ROW_WIDTH_BITS-1:0]    ROW_WIDTH_RESET    = 11'd1024;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd1024;

   typedef logic [GRAD_BITS-1:0]   grad_type;
   typedef logic [ENERGY_BITS-1:0] energy_type;

   localparam energy_type ENERGY_MAX = '1;

   typedef enum logic {
      REG_ROW_WIDTH    = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Per-pixel control decoded from the scan counters.
   typedef struct packed {
      logic first_row;
      logic has_right;
      logic end_of_row;
      logic end_of_frame;
   } pix_flags_type;

   function automatic energy_type min_energy(energy_type a, energy_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

FILE: rtl/sce_csr.sv
// -----------------------------------------------------------------------------
// sce_csr
// Register file: row width and frame height behind an APB-style port.
// -----------------------------------------------------------------------------
module sce_csr import sce_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]     csr_prdata,
   output logic [ROW_WIDTH_BITS-1:0]    row_width,
   output logic [FRAME_HEIGHT_BITS-1:0] frame_height
);

   logic [ROW_WIDTH_BITS-1:0]    row_width_ff;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height_ff;
   csr_index_type                reg_idx;
   logic                         wr_stb;

   // registers sit on 4-byte boundaries; bit 2 picks the register
   assign reg_idx = csr_index_type'(csr_paddr[2]);
   assign wr_stb  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= ROW_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (wr_stb) begin
         unique case (reg_idx)
            REG_ROW_WIDTH:    row_width_ff    <= csr_pwdata[ROW_WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[FRAME_HEIGHT_BITS-1:0];
            default:          row_width_ff    <= row_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROW_WIDTH:    csr_prdata = CSR_DATA_BITS'(row_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign row_width    = row_width_ff;
   assign frame_height = frame_height_ff;

endmodule

FILE: rtl/sce_scan.sv
// -----------------------------------------------------------------------------
// sce_scan
// Raster position counters; decodes row/frame ends and neighbor presence.
// -----------------------------------------------------------------------------
module sce_scan import sce_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ROW_WIDTH_BITS-1:0]       row_width,
   input  logic [FRAME_HEIGHT_BITS-1:0]    frame_height,
   output logic [$clog2(MAX_WIDTH)-1:0]    col,
   output pix_flags_type                   flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = (CW + 1 > ROW_WIDTH_BITS) ? CW + 1 : ROW_WIDTH_BITS;
   localparam int HW = (RW + 1 > FRAME_HEIGHT_BITS) ? RW + 1 : FRAME_HEIGHT_BITS;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [WW-1:0] width_eff, col_ext;
   logic [HW-1:0] height_eff;
   logic          eor, eof;

   // out-of-range settings clamp to 1 .. maximum
   always_comb begin
      priority if (row_width == '0)                   width_eff = WW'(1);
      else if (WW'(row_width) > WW'(MAX_WIDTH))      width_eff = WW'(MAX_WIDTH);
      else                                           width_eff = WW'(row_width);
   end

   always_comb begin
      priority if (frame_height == '0)                 height_eff = HW'(1);
      else if (HW'(frame_height) > HW'(MAX_HEIGHT))  height_eff = HW'(MAX_HEIGHT);
      else                                           height_eff = HW'(frame_height);
   end

   // at-or-past compares end a row early if the width shrank mid-row
   assign col_ext = WW'(col_ff);
   assign eor     = col_ext >= (width_eff - WW'(1));
   assign eof     = eor && (HW'(row_ff) >= (height_eff - HW'(1)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (eor) begin
            col_in = '0;
            row_in = eof ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col                = col_ff;
   assign flags.first_row    = (row_ff == '0);
   assign flags.has_right    = (col_ext + WW'(1)) < width_eff;
   assign flags.end_of_row   = eor;
   assign flags.end_of_frame = eof;

endmodule

FILE: rtl/sce_energy.sv
// -----------------------------------------------------------------------------
// sce_energy
// Row store, min-of-three-above plus gradient, and the result register.
// -----------------------------------------------------------------------------
module sce_energy import sce_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  grad_type                     in_grad,
   input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
   input  pix_flags_type                in_flags,
   output logic                         out_valid,
   input  logic                         out_ready,
   output energy_type                   out_energy,
   output logic                         out_end_of_row,
   output logic                         out_end_of_frame
);

`include "seam_cumulative_energy_assert.svh"

   localparam int CW = $clog2(MAX_WIDTH);

   // previous row's results; entry 0 is also mirrored in col0_ff
   energy_type    row_mem [MAX_WIDTH];
   energy_type    mem_q_ff;
   logic          fwd_ff;
   energy_type    fwd_data_ff;

   logic          s1_valid_ff;
   grad_type      s1_grad_ff;
   logic [CW-1:0] s1_col_ff;
   pix_flags_type s1_flags_ff;

   energy_type    left_ff, center_ff, col0_ff;

   logic          out_valid_ff, out_eor_ff, out_eof_ff;
   energy_type    out_energy_ff;

   logic          in_fire, s1_fire, rd_en, wr_en;
   logic [CW-1:0] rd_addr;
   energy_type    center_val, right_val, best_a, best, s1_result;
   logic [ENERGY_BITS:0] sum;

   assign s1_fire  = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || s1_fire;
   assign in_fire  = in_valid && in_ready;

   assign rd_addr = in_col + CW'(1);
   assign rd_en   = in_fire && in_flags.has_right;
   assign wr_en   = s1_fire;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[s1_col_ff] <= s1_result;
      end
      if (rd_en) begin
         mem_q_ff <= row_mem[rd_addr];
      end
   end

   // the store reads old data when the stage ahead writes the same entry
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (in_fire) begin
         fwd_ff <= wr_en && (s1_col_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         fwd_data_ff <= s1_result;
         s1_grad_ff  <= in_grad;
         s1_col_ff   <= in_col;
         s1_flags_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      center_val = (s1_col_ff == '0) ? col0_ff : center_ff;
      right_val  = '0;
      if (s1_flags_ff.has_right) begin
         right_val = fwd_ff ? fwd_data_ff : mem_q_ff;
      end
      best_a = (s1_col_ff != '0) ? min_energy(center_val, left_ff) : center_val;
      best   = s1_flags_ff.has_right ? min_energy(best_a, right_val) : best_a;
      sum    = {1'b0, best} + (ENERGY_BITS + 1)'(s1_grad_ff);
      priority if (s1_flags_ff.first_row) s1_result = ENERGY_BITS'(s1_grad_ff);
      else if (sum[ENERGY_BITS])          s1_result = ENERGY_MAX;
      else                                s1_result = sum[ENERGY_BITS-1:0];
   end

   // sliding window over the row above
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         center_ff <= '0;
      end else if (s1_fire) begin
         if (s1_flags_ff.end_of_row) begin
            left_ff   <= '0;
            center_ff <= '0;
         end else if (!s1_flags_ff.first_row) begin
            left_ff   <= center_val;
            center_ff <= right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && (s1_col_ff == '0)) begin
         col0_ff <= s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_energy_ff <= s1_result;
         out_eor_ff    <= s1_flags_ff.end_of_row;
         out_eof_ff    <= s1_flags_ff.end_of_frame;
      end
   end

   assign out_valid        = out_valid_ff;
   assign out_energy       = out_energy_ff;
   assign out_end_of_row   = out_eor_ff;
   assign out_end_of_frame = out_eof_ff;

   `SCE_ASSERT_NOW(a_first_row_pass, clock, reset, s1_fire && s1_flags_ff.first_row, s1_result == ENERGY_BITS'(s1_grad_ff), "first-row result differs from gradient")
   `SCE_ASSERT_NOW(a_result_covers_grad, clock, reset, s1_fire, s1_result >= ENERGY_BITS'(s1_grad_ff), "result below its own gradient")
   `SCE_ASSERT_NEXT(a_forward_capture, clock, reset, rd_en && wr_en && (s1_col_ff == rd_addr), fwd_ff, "same-entry read not forwarded")
   `SCE_ASSERT_NOW(a_accept_slot_free, clock, reset, in_fire, !s1_valid_ff || s1_fire, "item accepted over a held item")
   `SCE_ASSERT_NOW(a_frame_end_row_end, clock, reset, out_valid_ff && out_eof_ff, out_eor_ff, "frame end without row end")

endmodule

FILE: rtl/seam_cumulative_energy.sv
// -----------------------------------------------------------------------------
// seam_cumulative_energy
// Streaming cumulative seam-energy map: each pixel gets its gradient plus the
// least cumulative value of the three neighbors in the row above.
// -----------------------------------------------------------------------------
//   port group | direction | carries
//   req_*      | in        | gradient_in, one pixel per item, raster order
//   rsp_*      | out       | cumulative_energy, end_of_row (tlast), end_of_frame
//   csr_*      | in/out    | row_width (0x0), frame_height (0x4)
//
// One item per cycle unless rsp stalls; items pass the compute and output registers.
// Throughput is set by the row store: one read and one write port per cycle.
// req_tready drops only when the compute stage is full and rsp is stalled.
// Reset clears the scan counters and neighbor holds; the row store is not
// cleared; first-row reads are ignored, but widening mid-frame reads stale entries.
// -----------------------------------------------------------------------------
module seam_cumulative_energy import sce_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [23:0] gradient_in
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [35:0] cumulative_energy, rest zero
   output logic                     rsp_tlast,   // end_of_row
   output logic                     rsp_tuser,   // [0] end_of_frame
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [ROW_WIDTH_BITS-1:0]    row_width;
   logic [FRAME_HEIGHT_BITS-1:0] frame_height;
   logic [$clog2(MAX_WIDTH)-1:0] scan_col;
   pix_flags_type                scan_flags;
   logic                         eng_ready;
   logic                         req_fire;
   energy_type                   rsp_energy;

   assign req_tready = eng_ready;
   assign req_fire   = req_tvalid && eng_ready;
   assign csr_pready = 1'b1;

   sce_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .row_width    (row_width),
      .frame_height (frame_height)
   );

   sce_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_fire),
      .row_width    (row_width),
      .frame_height (frame_height),
      .col          (scan_col),
      .flags        (scan_flags)
   );

   sce_energy #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_energy (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (eng_ready),
      .in_grad          (req_tdata[GRAD_BITS-1:0]),
      .in_col           (scan_col),
      .in_flags         (scan_flags),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_energy       (rsp_energy),
      .out_end_of_row   (rsp_tlast),
      .out_end_of_frame (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_BITS'(rsp_energy);

endmodule

FILE: verif/tb_seam_cumulative_energy.sv
// -----------------------------------------------------------------------------
// tb_seam_cumulative_energy
// Self-checking bench for the cumulative seam-energy stream. Gradient items are
// fed in raster order with random gaps, results are drained with random stalls,
// and every result is checked against an in-bench energy accumulator that
// tracks the row store, scan counters and neighbor holds. Geometry registers
// are rewritten between phases, mid-row and mid-frame included.
// -----------------------------------------------------------------------------
module tb_seam_cumulative_energy;
   import sce_pkg::*;

   localparam int PIX_MAX_WIDTH  = 1024;
   localparam int PIX_MAX_HEIGHT = 4096;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam grad_type GRAD_MAX = '1;

   typedef struct packed {
      energy_type energy;
      logic       row_end;
      logic       frame_end;
   } pixel_result_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;   // [23:0] gradient_in
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;          // [35:0] cumulative_energy
   logic                     rsp_tlast;          // end_of_row
   logic                     rsp_tuser;          // [0] end_of_frame
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   seam_cumulative_energy #(
      .MAX_WIDTH  (PIX_MAX_WIDTH),
      .MAX_HEIGHT (PIX_MAX_HEIGHT)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // accumulator state, mirrors the block
   logic [ROW_WIDTH_BITS-1:0]    width_reg  = ROW_WIDTH_RESET;
   logic [FRAME_HEIGHT_BITS-1:0] height_reg = FRAME_HEIGHT_RESET;
   energy_type                   row_store [PIX_MAX_WIDTH];
   bit                           stored    [PIX_MAX_WIDTH];
   logic [9:0]                   col_cnt     = '0;
   logic [11:0]                  row_cnt     = '0;
   energy_type                   hold_left   = '0;
   energy_type                   hold_center = '0;

   grad_type         gradient_q [$];
   pixel_result_type seam_energy_q [$];
   pixel_result_type want;

   int          send_wait      = 0;
   int          stall_left     = 0;
   int          gap_pct        = 0;
   int          stall_pct      = 0;
   int          error_count    = 0;
   int          pixels_checked = 0;
   int          rows_closed    = 0;
   int          frames_closed  = 0;
   int          config_writes  = 0;
   int unsigned cycle_count    = 0;

   function automatic pixel_result_type cumulate_pixel(grad_type grad);
      int unsigned      span;
      int unsigned      depth;
      int unsigned      col;
      energy_type       center;
      energy_type       best;
      energy_type       right;
      logic [ENERGY_BITS:0] total;
      pixel_result_type res;
      span  = (width_reg == 0) ? 1 :
              (width_reg > PIX_MAX_WIDTH) ? PIX_MAX_WIDTH : width_reg;
      depth = (height_reg == 0) ? 1 :
              (height_reg > PIX_MAX_HEIGHT) ? PIX_MAX_HEIGHT : height_reg;
      col = col_cnt;
      res.row_end   = (col_cnt >= span - 1);
      res.frame_end = res.row_end && (row_cnt >= depth - 1);
      if (row_cnt == 0) begin
         res.energy = grad;
      end else begin
         center = (col == 0) ? row_store[0] : hold_center;
         best   = center;
         right  = '0;
         if (col > 0 && hold_left < best) best = hold_left;
         if (col + 1 < span) begin
            right = row_store[col + 1];
            if (right < best) best = right;
         end
         total = best + grad;
         res.energy  = (total > ENERGY_MAX) ? ENERGY_MAX : total[ENERGY_BITS-1:0];
         hold_left   = center;
         hold_center = right;
      end
      row_store[col] = res.energy;
      stored[col]    = 1'b1;
      if (res.row_end) begin
         col_cnt     = '0;
         hold_left   = '0;
         hold_center = '0;
         row_cnt     = res.frame_end ? 12'd0 : row_cnt + 12'd1;
      end else begin
         col_cnt = col_cnt + 10'd1;
      end
      return res;
   endfunction

   // entries 0..n-1 all written at least once
   function automatic int unsigned stored_prefix();
      int unsigned n;
      n = 0;
      while (n < PIX_MAX_WIDTH && stored[n]) n++;
      return n;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(12, 24);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 25;
         default: return 60;
      endcase
   endfunction

   function automatic grad_type random_gradient();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return GRAD_MAX;
         2: return grad_type'($urandom_range(0, 255));
         3: return GRAD_MAX - grad_type'($urandom_range(0, 255));
         default: return grad_type'($urandom());
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_wait > 0) begin
            send_wait  <= send_wait - 1;
            req_tvalid <= 1'b0;
         end else if (gradient_q.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= gradient_q.pop_front();
            if ($urandom_range(0, 99) < gap_pct) send_wait <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accept side: predict on input, check on output
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (req_tvalid && req_tready)
            seam_energy_q.push_back(cumulate_pixel(req_tdata[GRAD_BITS-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (seam_energy_q.size() == 0) begin
               $display("%0t: unexpected item energy %h last %b user %b", $time,
                        rsp_tdata[ENERGY_BITS-1:0], rsp_tlast, rsp_tuser);
               error_count++;
            end else begin
               want = seam_energy_q.pop_front();
               if (rsp_tdata[ENERGY_BITS-1:0] !== want.energy) begin
                  $display("%0t: pixel %0d energy expected %h got %h", $time,
                           pixels_checked, want.energy, rsp_tdata[ENERGY_BITS-1:0]);
                  error_count++;
               end
               if (rsp_tlast !== want.row_end) begin
                  $display("%0t: pixel %0d end_of_row expected %b got %b", $time,
                           pixels_checked, want.row_end, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== want.frame_end) begin
                  $display("%0t: pixel %0d end_of_frame expected %b got %b", $time,
                           pixels_checked, want.frame_end, rsp_tuser);
                  error_count++;
               end
               if (want.row_end) rows_closed++;
               if (want.frame_end) frames_closed++;
            end
            pixels_checked++;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items still expected", $time,
                  seam_energy_q.size());
         $display("tb_seam_cumulative_energy: FAIL");
         $finish;
      end
   end

   // wait until every item is sent and every result is back
   task automatic drain();
      while (gradient_q.size() != 0 || req_tvalid || seam_energy_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_ROW_WIDTH) width_reg = value[ROW_WIDTH_BITS-1:0];
      else height_reg = value[FRAME_HEIGHT_BITS-1:0];
      config_writes++;
   endtask

   task automatic csr_check(input csr_index_type idx);
      logic [31:0] got;
      logic [31:0] value;
      logic [31:0] mask;
      value = (idx == REG_ROW_WIDTH) ? 32'(width_reg) : 32'(height_reg);
      mask  = (idx == REG_ROW_WIDTH) ? 32'h7FF : 32'h1FFF;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (((got ^ value) & mask) != 0) begin
         $display("%0t: register %s read expected %h got %h", $time, idx.name(),
                  value & mask, got & mask);
         error_count++;
      end
      @(negedge clock);
   endtask

   // Geometry change at idle. Inside a frame past its first row a wider row
   // would read store entries never written, so the width is held to the
   // written prefix there.
   task automatic set_geometry(input int unsigned width_val, input int unsigned height_val);
      int unsigned span;
      drain();
      span = (width_val == 0) ? 1 : (width_val > PIX_MAX_WIDTH) ? PIX_MAX_WIDTH : width_val;
      if (row_cnt != 0 && span > stored_prefix()) width_val = stored_prefix();
      // upper bits above both fields carry junk the block must drop
      csr_write(REG_ROW_WIDTH, width_val | ($urandom() << 13));
      csr_write(REG_FRAME_HEIGHT, height_val | ($urandom() << 13));
      csr_check(REG_ROW_WIDTH);
      csr_check(REG_FRAME_HEIGHT);
   endtask

   // one pixel with width and height acting as 1 closes any row and frame
   task automatic restart_frame();
      set_geometry(0, 0);
      gradient_q.push_back(random_gradient());
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned width_val;
      int unsigned height_val;
      int unsigned count;
      int          r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check(REG_ROW_WIDTH);
      csr_check(REG_FRAME_HEIGHT);

      // 4x3 frame with zero and full-scale gradients at edges and interior
      set_geometry(4, 3);
      gradient_q.push_back('0);
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back(grad_type'(1));
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back('0);
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back(grad_type'(24'h000001));
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back(GRAD_MAX);
      gradient_q.push_back(grad_type'(24'h800000));
      gradient_q.push_back(grad_type'(24'h7FFFFF));
      // zero width and height act as one
      set_geometry(0, 0);
      repeat (3) gradient_q.push_back(random_gradient());
      // narrowing inside a row, then the frame height inside a frame
      set_geometry(5, 4);
      repeat (7) gradient_q.push_back(random_gradient());
      set_geometry(2, 4);
      repeat (2) gradient_q.push_back(random_gradient());
      set_geometry(2, 1);
      repeat (2) gradient_q.push_back(random_gradient());

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase == 2) begin
            // full width (register past the limit) for one row of two
            restart_frame();
            set_geometry(2047, 2);
            gap_pct   = 5;
            stall_pct = 5;
            repeat (PIX_MAX_WIDTH) gradient_q.push_back(random_gradient());
            random_sent += PIX_MAX_WIDTH;
         end
         if ($urandom_range(0, 1) == 1) begin
            restart_frame();
            random_sent++;
         end
         r = $urandom_range(0, 99);
         if (r < 50) width_val = $urandom_range(1, 8);
         else if (r < 80) width_val = $urandom_range(9, 40);
         else if (r < 90) width_val = $urandom_range(41, 200);
         else if (r < 95) width_val = 0;
         else width_val = $urandom_range(PIX_MAX_WIDTH, 2047);
         r = $urandom_range(0, 99);
         if (r < 40) height_val = $urandom_range(1, 4);
         else if (r < 70) height_val = $urandom_range(5, 16);
         else if (r < 80) height_val = 0;
         else if (r < 90) height_val = $urandom_range(PIX_MAX_HEIGHT, 8191);
         else height_val = $urandom_range(0, 8191);
         set_geometry(width_val, height_val);
         gap_pct   = pick_pct();
         stall_pct = pick_pct();
         count = $urandom_range(10, 120);
         repeat (count) gradient_q.push_back(random_gradient());
         random_sent += count;
         phase++;
      end
      drain();
      repeat (10) @(negedge clock);

      $display("Checked %0d pixels over %0d rows and %0d frames, %0d register writes.",
               pixels_checked, rows_closed, frames_closed, config_writes);
      $display("Geometry ran from 0/0 to 2047/8191 with mid-row changes; %0d mismatches.",
               error_count);
      if (error_count == 0) begin
         $display("tb_seam_cumulative_energy: PASS");
      end else begin
         $display("tb_seam_cumulative_energy: FAIL");
      end
      $finish;
   end

endmodule
